### hdl/sorted_insert_array_unit_defines.svh
// Assertion macros for the sorted insert array unit checker.
// Included by files that hold concurrent assertions; no other dependencies.
`ifndef SORTED_INSERT_ARRAY_UNIT_DEFINES_SVH
`define SORTED_INSERT_ARRAY_UNIT_DEFINES_SVH

// Checked while reset is released.
`define SIA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SIA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sia_pkg.sv
// Shared types and constants for the sorted insert array unit.
// No dependencies; imported by every module of the block.
package sia_pkg;

    localparam int DEPTH     = 256;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 9;
    localparam int LIM_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int GRP       = 16;
    localparam int NGRP      = (DEPTH + GRP - 1) / GRP;

    localparam int POS_W     = 8;
    localparam int VAL_W     = 32;
    localparam int COUNT_W   = 9;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 48;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef struct packed {
        logic do_ins;
        logic do_rem;
        key_t key;
        idx_t pos;
        cnt_t count;
    } cell_ctrl_t;

endpackage

### hdl/sorted_insert_array_unit.sv
// Sorted insert array unit: an ascending list of unsigned keys in a chain of cells.
// Input transaction (s_*): insert a key, look up or remove an entry by index.
// Output transaction (m_*): one result per input: value read, entry count, status.
// Configuration: cfg_wr_en/cfg_wr_data write the capacity; write only while idle.
// All cells compare against the insert key in parallel; the row shifts one place
// up (insert) or down (remove) at the accepting edge, so one transaction per cycle
// is taken when the output side keeps up.
// The result passes through the middle stage and the output register; the read path goes
// through a registered OR over groups of 16 cells, then a final OR into the output.
// An insert into a full list returns status 1; an index at or above the count
// returns status 2; both leave the list unchanged.
// When m_tready is low the result holds; one more transaction may be accepted into
// the middle stage, then s_tready drops until the output is taken.
// Reset (aresetn low, synchronous) empties the list and sets capacity to 256;
// stored keys themselves are not cleared.
// Depends on sia_pkg, sia_cell, sia_reduce.
module sorted_insert_array_unit import sia_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op[1:0], key_value[33:2], position[41:34]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // read_value[31:0], entry_count[40:32], status[42:41]
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    logic [CAP_W-1:0] cap_reg;
    cnt_t             count_reg;
    cnt_t             count_next;

    logic             p1_valid_reg;
    cnt_t             p1_count_reg;
    status_t          p1_status_reg;
    logic             p1_take_reg;

    logic             m_valid_reg;
    logic [VAL_W-1:0] m_value_reg;
    cnt_t             m_count_reg;
    status_t          m_status_reg;

    op_t              in_op;
    key_t             in_key;
    logic [POS_W-1:0] in_pos;
    logic             accept;
    logic             out_free;
    logic             p1_adv;
    logic             full;
    logic             out_of_range;
    logic             do_ins;
    logic             do_rem;
    logic             take;
    status_t          status;
    cell_ctrl_t       ctrl;
    key_t             read_or;

    key_t                 cell_key  [DEPTH];
    logic                 cell_less [DEPTH];
    key_t                 cell_hit  [DEPTH];
    key_t [NGRP*GRP-1:0]  hit_pad;
    key_t                 group_val [NGRP];

    assign in_op  = op_t'(s_tdata[1:0]);
    assign in_key = key_t'(s_tdata[33:2]);
    assign in_pos = s_tdata[41:34];

    assign out_free = !m_valid_reg || m_tready;
    assign p1_adv   = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign full = (LIM_W'(count_reg) >= LIM_W'(cap_reg)) || (count_reg == cnt_t'(DEPTH));
    assign out_of_range = LIM_W'(in_pos) >= LIM_W'(count_reg);

    always_comb begin
        do_ins = 1'b0;
        do_rem = 1'b0;
        take   = 1'b0;
        status = ST_DONE;
        case (in_op)
            OP_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (out_of_range) begin
                    status = ST_RANGE;
                end else begin
                    take = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (out_of_range) begin
                    status = ST_RANGE;
                end else begin
                    take   = 1'b1;
                    do_rem = 1'b1;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (accept && do_ins) begin
            count_next = count_reg + cnt_t'(1);
        end else if (accept && do_rem) begin
            count_next = count_reg - cnt_t'(1);
        end
    end

    assign ctrl.do_ins = accept && do_ins;
    assign ctrl.do_rem = accept && do_rem;
    assign ctrl.key    = in_key;
    assign ctrl.pos    = idx_t'(in_pos);
    assign ctrl.count  = count_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sia_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .cell_idx  (idx_t'(i)),
            .prev_key  ((i == 0) ? key_t'(0) : cell_key[(i == 0) ? 0 : i - 1]),
            .prev_less ((i == 0) ? 1'b1 : cell_less[(i == 0) ? 0 : i - 1]),
            .next_key  (cell_key[(i == DEPTH - 1) ? i : i + 1]),
            .key_q     (cell_key[i]),
            .less      (cell_less[i]),
            .hit       (cell_hit[i])
        );
    end

    for (genvar i = 0; i < NGRP * GRP; i++) begin : g_pad
        if (i < DEPTH) begin : g_real
            assign hit_pad[i] = cell_hit[i];
        end else begin : g_zero
            assign hit_pad[i] = '0;
        end
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        sia_reduce u_reduce (
            .aclk    (aclk),
            .en      (accept),
            .hits    (hit_pad[g*GRP +: GRP]),
            .group_q (group_val[g])
        );
    end

    always_comb begin
        read_or = '0;
        for (int g = 0; g < NGRP; g++) begin
            read_or = read_or | group_val[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CAP_W'(256);
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_count_reg  <= count_next;
            p1_status_reg <= status;
            p1_take_reg   <= take;
        end
        if (p1_adv) begin
            m_value_reg  <= p1_take_reg ? VAL_W'(read_or) : '0;
            m_count_reg  <= p1_count_reg;
            m_status_reg <= p1_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_W - VAL_W - COUNT_W - 2)'(0), m_status_reg,
                       COUNT_W'(m_count_reg), m_value_reg};

endmodule

### hdl/sia_cell.sv
// One storage cell of the sorted chain: holds one key, compares it with the
// insert key and shifts to or from its neighbors. Depends on sia_pkg.
module sia_cell import sia_pkg::*; (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  idx_t       cell_idx,
    input  key_t       prev_key,
    input  logic       prev_less,
    input  key_t       next_key,
    output key_t       key_q,
    output logic       less,
    output key_t       hit
);

    key_t key_reg;
    key_t key_next;
    logic valid;

    assign valid = cnt_t'(cell_idx) < ctrl.count;
    assign less  = valid && (key_reg < ctrl.key);
    assign hit   = (cell_idx == ctrl.pos) ? key_reg : '0;
    assign key_q = key_reg;

    always_comb begin
        key_next = key_reg;
        if (ctrl.do_ins && !less) begin
            key_next = prev_less ? ctrl.key : prev_key;
        end else if (ctrl.do_rem && (cell_idx >= ctrl.pos)) begin
            key_next = next_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

### hdl/sia_reduce.sv
// Registered OR of one group of cell read taps (only the addressed cell is
// nonzero). Depends on sia_pkg.
module sia_reduce import sia_pkg::*; (
    input  logic           aclk,
    input  logic           en,
    input  key_t [GRP-1:0] hits,
    output key_t           group_q
);

    key_t group_reg;
    key_t group_next;

    always_comb begin
        group_next = '0;
        for (int i = 0; i < GRP; i++) begin
            group_next = group_next | hits[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            group_reg <= group_next;
        end
    end

    assign group_q = group_reg;

endmodule

### hdl/sia_checker.sv
// Port-level checker for the sorted insert array unit, bound to the top level.
// Depends on sia_pkg and sorted_insert_array_unit_defines.svh.
`include "sorted_insert_array_unit_defines.svh"

module sia_checker import sia_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    `SIA_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "stalled output transaction changed")
    `SIA_ASSERT(a_status_code, aclk, aresetn,
        m_tvalid |-> (m_tdata[42:41] == ST_DONE) || (m_tdata[42:41] == ST_FULL) ||
        (m_tdata[42:41] == ST_RANGE),
        "status code out of set")
    `SIA_ASSERT(a_count_bound, aclk, aresetn,
        m_tvalid |-> m_tdata[40:32] <= COUNT_W'(DEPTH),
        "entry count above depth")
    `SIA_ASSERT(a_refused_zero, aclk, aresetn,
        m_tvalid && (m_tdata[42:41] != ST_DONE) |-> m_tdata[31:0] == '0,
        "refused transaction returned data")
    `SIA_ASSERT_ALWAYS(a_reset_idle, aclk,
        !aresetn |=> !m_tvalid,
        "output valid after reset")

endmodule

bind sorted_insert_array_unit sia_checker u_sia_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb_sorted_insert_array_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_insert_array_unit: directed and random insert,
// lookup and remove traffic checked against an in-bench sorted list model.
// Depends on sia_pkg and the sorted_insert_array_unit RTL only.
module tb_sorted_insert_array_unit;
    import sia_pkg::*;

    typedef struct {
        op_t              op;
        key_t             key;
        logic [POS_W-1:0] pos;
        bit               wait_drain;
    } list_item_t;

    typedef struct {
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } list_result_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    sorted_insert_array_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sorted list model
    key_t list_keys [DEPTH];
    int   list_count    = 0;
    int   list_capacity = 256;
    int   peak_count    = 0;

    list_item_t   op_queue[$];
    list_result_t results_due[$];
    list_item_t   current_item;

    int send_idle_pct = 15;
    int recv_idle_pct = 71;
    int random_items  = 0;
    int mismatches    = 0;
    int n_inserts = 0, n_lookups = 0, n_removes = 0, n_noops = 0;
    int n_full = 0, n_range = 0;

    function automatic list_result_t apply_list_op(list_item_t it);
        list_result_t res;
        int limit;
        int slot;
        res.value  = '0;
        res.status = ST_DONE;
        limit = (list_capacity < DEPTH) ? list_capacity : DEPTH;
        case (it.op)
            OP_INSERT: begin
                if (list_count >= limit) begin
                    res.status = ST_FULL;
                    n_full++;
                end else begin
                    slot = 0;
                    while (slot < list_count && list_keys[slot] < it.key) slot++;
                    for (int k = list_count; k > slot; k--) list_keys[k] = list_keys[k-1];
                    list_keys[slot] = it.key;
                    list_count++;
                    n_inserts++;
                    if (list_count > peak_count) peak_count = list_count;
                end
            end
            OP_LOOKUP, OP_REMOVE: begin
                if (int'(it.pos) >= list_count) begin
                    res.status = ST_RANGE;
                    n_range++;
                end else begin
                    res.value = list_keys[it.pos];
                    if (it.op == OP_REMOVE) begin
                        for (int k = it.pos; k + 1 < list_count; k++) list_keys[k] = list_keys[k+1];
                        list_count--;
                        n_removes++;
                    end else begin
                        n_lookups++;
                    end
                end
            end
            default: n_noops++;
        endcase
        res.count = list_count[COUNT_W-1:0];
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(apply_list_op(current_item));
            end
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() != 0
                        && !(op_queue[0].wait_drain && results_due.size() != 0)
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    current_item = op_queue.pop_front();
                    s_tdata  <= {6'b0, current_item.pos, current_item.key, current_item.op};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : result_monitor
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.value, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[40:32] !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, m_tdata[40:32]);
                    mismatches++;
                end
                if (m_tdata[42:41] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tdata[42:41]);
                    mismatches++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic queue_item(op_t op, key_t key, logic [POS_W-1:0] pos, bit drain);
        op_queue.push_back('{op, key, pos, drain});
    endtask

    task automatic wait_idle();
        while (op_queue.size() != 0 || s_tvalid || results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_capacity(int value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CAP_W-1:0];
        list_capacity = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(int n, int p_ins, int p_look, int p_rem);
        int               roll;
        op_t              op;
        key_t             key;
        logic [POS_W-1:0] pos;
        bit               drain;
        for (int i = 0; i < n; i++) begin
            while (op_queue.size() >= 4) @(posedge aclk);
            roll = $urandom_range(0, 99);
            if (roll < p_ins) op = OP_INSERT;
            else if (roll < p_ins + p_look) op = OP_LOOKUP;
            else if (roll < p_ins + p_look + p_rem) op = OP_REMOVE;
            else op = OP_NONE;

            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                key = $urandom();
            end else if (roll < 60) begin
                key = $urandom_range(0, 7);
            end else if (roll < 70) begin
                case ($urandom_range(0, 2))
                    0:       key = '0;
                    1:       key = '1;
                    default: key = 32'h8000_0000;
                endcase
            end else if (list_count > 0) begin
                key = list_keys[$urandom_range(0, list_count - 1)] + $urandom_range(0, 2) - 1;
            end else begin
                key = $urandom();
            end

            roll = $urandom_range(0, 99);
            if (roll < 70 && list_count > 0) pos = POS_W'($urandom_range(0, list_count - 1));
            else if (roll < 80 && list_count < DEPTH) pos = list_count[POS_W-1:0];
            else pos = POS_W'($urandom_range(0, 255));

            drain = (i == 0) || ($urandom_range(0, 99) < 2);
            queue_item(op, key, pos, drain);
            random_items++;
            if (random_items == 400) begin
                send_idle_pct = 71;
                recv_idle_pct = 15;
            end else if (random_items == 800) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, no-op, duplicates and extreme keys
        queue_item(OP_LOOKUP, '1, 8'd0, 1'b0);
        queue_item(OP_REMOVE, '1, 8'd0, 1'b0);
        queue_item(OP_NONE, '1, 8'hff, 1'b0);
        queue_item(OP_INSERT, 32'hffff_ffff, 8'hff, 1'b0);
        queue_item(OP_INSERT, 32'h0000_0000, 8'h00, 1'b0);
        queue_item(OP_INSERT, 32'h8000_0000, 8'h00, 1'b0);
        queue_item(OP_INSERT, 32'd5, 8'h00, 1'b0);
        queue_item(OP_INSERT, 32'd5, 8'h00, 1'b0);
        queue_item(OP_INSERT, 32'h0000_0000, 8'h00, 1'b0);
        queue_item(OP_LOOKUP, 32'h0, 8'd0, 1'b0);
        queue_item(OP_LOOKUP, 32'h0, 8'd5, 1'b0);
        queue_item(OP_LOOKUP, 32'h0, 8'd6, 1'b0);
        queue_item(OP_LOOKUP, 32'h0, 8'hff, 1'b0);
        queue_item(OP_REMOVE, 32'h0, 8'd5, 1'b0);
        queue_item(OP_REMOVE, 32'h0, 8'd0, 1'b0);
        queue_item(OP_REMOVE, 32'h0, 8'd1, 1'b0);
        queue_item(OP_NONE, 32'h0, 8'h00, 1'b0);

        // capacity below the current fill
        set_capacity(2);
        queue_item(OP_INSERT, 32'd9, 8'h00, 1'b0);
        queue_item(OP_LOOKUP, 32'h0, 8'd2, 1'b0);
        queue_item(OP_REMOVE, 32'h0, 8'd0, 1'b0);
        queue_item(OP_REMOVE, 32'h0, 8'd0, 1'b0);
        queue_item(OP_INSERT, 32'd3, 8'h00, 1'b0);
        queue_item(OP_INSERT, 32'd4, 8'h00, 1'b0);

        set_capacity(511);
        run_phase(150, 60, 20, 15);
        run_phase(300, 92, 4, 2);
        set_capacity(3);
        run_phase(120, 20, 30, 47);
        set_capacity(0);
        run_phase(80, 40, 20, 37);
        run_phase(250, 0, 12, 85);
        set_capacity(1);
        run_phase(100, 45, 25, 27);
        set_capacity(40);
        run_phase(200, 45, 25, 27);

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("Ran %0d inserts, %0d lookups, %0d removes, %0d no-ops; %0d refused as full,",
                 n_inserts, n_lookups, n_removes, n_noops, n_full);
        $display("%0d refused on index, peak fill %0d entries, capacities 256/2/511/3/0/1/40.",
                 n_range, peak_count);
        if (mismatches == 0) begin
            $display("sorted_insert_array_unit regression: pass");
        end else begin
            $display("sorted_insert_array_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", results_due.size());
        $display("sorted_insert_array_unit regression: fail");
        $finish;
    end

endmodule
